FILE: rtl/a64dp_pkg.sv
// shared types and constants for the a64 data-processing-immediate unit
// no dependencies; imported by a64dp_alu and a64_immediate_data_processing
package a64dp_pkg;

	// opi group codes, instruction bits 25..23
	localparam logic [2:0] OPI_ARITH = 3'b010;
	localparam logic [2:0] OPI_WIDE  = 3'b101;

	// opc codes of the wide-move group, instruction bits 30..29
	localparam logic [1:0] OPC_MOVN  = 2'b00;
	localparam logic [1:0] OPC_UNDEF = 2'b01;
	localparam logic [1:0] OPC_MOVZ  = 2'b10;
	localparam logic [1:0] OPC_MOVK  = 2'b11;

	// register number that names the zero register
	localparam logic [4:0] ZERO_REG = 5'd31;

	// padded width of the result word
	localparam int unsigned OUT_DATA_W = 80;

	// execute result handed from the alu to the write-back stage
	typedef struct packed {
		logic        invalid;
		logic        flags_we;
		logic [3:0]  flags;
		logic [63:0] value;
	} alu_out_t;

endpackage

FILE: rtl/a64dp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; holds the register file of the unit
module a64dp_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port, read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/a64dp_alu.sv
// decode and execute of one data-processing-immediate instruction
// depends on a64dp_pkg; operand comes from the register file read
module a64dp_alu (
	input  logic [31:0]          instruction_word,
	input  logic [63:0]          operand,
	output a64dp_pkg::alu_out_t  alu_out
);
	import a64dp_pkg::*;

	logic        sf;
	logic [2:0]  opi;
	logic [1:0]  opc;
	logic [1:0]  hw;
	logic [63:0] mask;
	logic [63:0] a;
	logic [63:0] b;
	logic        sub;
	logic [64:0] sum;
	logic [63:0] res;
	logic        top_res;
	logic        top_a;
	logic        top_b;
	logic        carry;
	logic        ovf;
	logic [63:0] imm_wide;
	logic [63:0] hole;

	// instruction fields
	assign sf   = instruction_word[31];
	assign opi  = instruction_word[25:23];
	assign opc  = instruction_word[30:29];
	assign hw   = instruction_word[22:21];
	assign mask = sf ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;

	// add or subtract through one adder, subtract as a + ~b + 1
	assign a   = operand & mask;
	assign b   = instruction_word[22] ? {40'd0, instruction_word[21:10], 12'd0}
		: {52'd0, instruction_word[21:10]};
	assign sub = opc[1];
	assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {64'd0, sub};
	assign res = sum[63:0] & mask;

	// sign bits at the operation width
	assign top_res = sf ? res[63] : res[31];
	assign top_a   = sf ? a[63] : a[31];
	assign top_b   = sf ? b[63] : b[31];

	// carry is no-borrow for subtract, carry out of the width for add
	assign carry = (sub || sf) ? sum[64] : sum[32];
	assign ovf   = sub ? ((top_a ^ top_b) & (top_a ^ top_res))
		: (~(top_a ^ top_b) & (top_a ^ top_res));

	// wide-move immediate and the halfword it replaces
	assign imm_wide = {48'd0, instruction_word[20:5]} << {hw, 4'd0};
	assign hole     = 64'h0000_0000_0000_FFFF << {hw, 4'd0};

	// group select
	always_comb begin
		alu_out = '0;
		unique case (opi)
			OPI_ARITH: begin
				alu_out.value    = res;
				alu_out.flags_we = opc[0];
				alu_out.flags    = {top_res, (res == 64'd0), carry, ovf};
			end
			OPI_WIDE: begin
				if (opc == OPC_UNDEF || (!sf && hw[1])) begin
					alu_out.invalid = 1'b1;
				end else begin
					unique case (opc)
						OPC_MOVN: alu_out.value = ~imm_wide & mask;
						OPC_MOVZ: alu_out.value = imm_wide & mask;
						OPC_MOVK: alu_out.value = ((operand & ~hole) | imm_wide) & mask;
						default:  alu_out.value = '0;
					endcase
				end
			end
			default: begin
				alu_out.invalid = 1'b1;
			end
		endcase
	end

endmodule

FILE: rtl/a64_immediate_data_processing.sv
// Executes one A64 add/sub-immediate or wide-move instruction word per input word against a
// 31-entry 64-bit register file and an NZCV flag register, giving one result word each.
// The unit takes one instruction per cycle while its output is not stalled; the synchronous
// register-file ram read is registered into stage 1 as the instruction is taken, and execute
// and write-back then load the output register. A register written by one instruction and read
// by the next is forwarded around the ram. After reset all registers read zero through per-entry
// valid bits, so no clearing pass is needed. Output back-pressure stalls the execute stage, and
// the input stalls only once that stage is full.
// depends on a64dp_pkg, a64dp_ram, a64dp_alu
module a64_immediate_data_processing #(
	parameter int unsigned REGISTER_COUNT = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	// instruction word: instruction_word[31:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	// result word, from bit 0: dest_index[4:0], written, result_value[63:0],
	// flags_nzcv[3:0], invalid, zero padding[4:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [a64dp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import a64dp_pkg::*;

	localparam int unsigned IDX_W = $clog2(REGISTER_COUNT);

	logic                      s_accept;
	logic                      s1_done;
	logic [4:0]                raddr;
	logic                      rd_fwd;
	logic [IDX_W-1:0]          ram_waddr;
	logic [63:0]               ram_rdata;
	logic                      ram_we;
	logic [63:0]               operand;
	alu_out_t                  alu_out;
	logic [4:0]                rd_s1;
	logic                      written;
	logic [63:0]               wb_value;
	logic [3:0]                flags_next;

	logic                      s1_valid_q;
	logic [31:0]               instr_s1;
	logic                      zero_s1;
	logic                      vld_s1;
	logic                      fwd_s1;
	logic [63:0]               fwd_data_s1;
	logic [REGISTER_COUNT-1:0] valid_q;
	logic [3:0]                flags_q;
	logic                      out_valid_q;
	logic [OUT_DATA_W-1:0]     out_data_q;

	// handshake: stage 1 drains into the output register when it is free or taken
	assign s1_done       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_done;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// read address: rn for arithmetic, rd for movk
	assign raddr  = (s_axis_tdata[25:23] == OPI_ARITH) ? s_axis_tdata[9:5] : s_axis_tdata[4:0];
	assign rd_fwd = s1_done && ram_we && (ram_waddr == raddr[IDX_W-1:0]);

	// write-back decision
	assign rd_s1      = instr_s1[4:0];
	assign written    = !alu_out.invalid && (rd_s1 < REGISTER_COUNT);
	assign ram_we     = s1_done && written;
	assign ram_waddr  = rd_s1[IDX_W-1:0];
	assign wb_value   = written ? alu_out.value : 64'd0;
	assign flags_next = alu_out.flags_we ? alu_out.flags : flags_q;

	a64dp_ram #(
		.WIDTH (64),
		.DEPTH (REGISTER_COUNT)
	) u_regfile (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (alu_out.value),
		.re    (s_accept),
		.raddr (raddr[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// operand: zero register, forwarded write, never-written entry, or ram data
	always_comb begin
		if (zero_s1) begin
			operand = 64'd0;
		end else if (fwd_s1) begin
			operand = fwd_data_s1;
		end else if (vld_s1) begin
			operand = ram_rdata;
		end else begin
			operand = 64'd0;
		end
	end

	a64dp_alu u_alu (
		.instruction_word (instr_s1),
		.operand          (operand),
		.alu_out          (alu_out)
	);

	// stage 1 payload, captured with the ram read
	always_ff @(posedge clk) begin
		if (s_accept) begin
			instr_s1    <= s_axis_tdata;
			zero_s1     <= (raddr >= REGISTER_COUNT);
			vld_s1      <= (raddr < REGISTER_COUNT) ? valid_q[raddr[IDX_W-1:0]] : 1'b0;
			fwd_s1      <= rd_fwd;
			fwd_data_s1 <= alu_out.value;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (s1_done) begin
			out_data_q <= {5'd0, alu_out.invalid, flags_next, wb_value, written, rd_s1};
		end
	end

	// control state: stage valid, output valid, register valid bits, flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			flags_q     <= 4'd0;
		end else begin
			if (s_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_done) begin
				out_valid_q <= 1'b1;
				flags_q     <= flags_next;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// an invalid word never reports a write or a value
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[74]) |-> (!m_axis_tdata[5] && m_axis_tdata[69:6] == 64'd0))
		else $error("invalid result word carries a write");

	// the zero register is never written into the ram
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (rd_s1 < REGISTER_COUNT))
		else $error("write to zero register reached the register file");

	// flags only move when a flag-setting instruction completes
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(flags_q) |-> $past(s1_done && alu_out.flags_we))
		else $error("flags changed without a flag-setting instruction");

	// a result loaded into the output register is shown on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_done |=> m_axis_tvalid)
		else $error("completed instruction lost its result word");

endmodule

FILE: verif/tb.sv
// testbench for a64_immediate_data_processing: sends A64 add/sub-immediate and wide-move words
// and checks every result word against a software copy of the register file and nzcv flags
// depends on a64dp_pkg and the rtl of the unit
module tb;
	import a64dp_pkg::*;

	// opc codes of the add/sub-immediate group
	localparam logic [1:0] ARITH_ADD  = 2'b00;
	localparam logic [1:0] ARITH_ADDS = 2'b01;
	localparam logic [1:0] ARITH_SUB  = 2'b10;
	localparam logic [1:0] ARITH_SUBS = 2'b11;
	// class bits of a real data-processing-immediate word, bits 28..26
	localparam logic [2:0] CLASS_DPI  = 3'b100;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned DRAIN_LIMIT = 5000;

	// one result word, packed exactly as on m_axis_tdata[74:0]
	typedef struct packed {
		logic        invalid;
		logic [3:0]  nzcv;
		logic [63:0] value;
		logic        written;
		logic [4:0]  dest;
	} dp_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// architectural state as the testbench sees it
	logic [63:0] shadow_x [0:30];
	logic [3:0]  shadow_nzcv;
	dp_result_t  pending_results [$];

	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned words_sent = 0;
	int unsigned results_checked = 0;
	int unsigned undefined_count = 0;
	int unsigned flag_updates = 0;
	int unsigned error_count = 0;

	a64_immediate_data_processing u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the unit hangs
	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

	// word encoders
	function automatic logic [31:0] enc_arith(input logic sf, input logic [1:0] op,
			input logic sh, input logic [11:0] imm12, input logic [4:0] rn,
			input logic [4:0] rd);
		return {sf, op, CLASS_DPI, OPI_ARITH, sh, imm12, rn, rd};
	endfunction

	function automatic logic [31:0] enc_wide(input logic sf, input logic [1:0] opc,
			input logic [1:0] hw, input logic [15:0] imm16, input logic [4:0] rd);
		return {sf, opc, CLASS_DPI, OPI_WIDE, hw, imm16, rd};
	endfunction

	// executes one word on the shadow state and returns the result it should give
	function automatic dp_result_t execute_word(input logic [31:0] w);
		dp_result_t  r;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [1:0]  opc;
		logic [1:0]  hw;
		logic        sf;
		logic        bad;
		logic [63:0] wmask;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] res;
		logic [63:0] op;
		logic [63:0] hole;
		logic [63:0] old;
		logic        c;
		logic        v;
		int          top;

		rd = w[4:0];
		rn = w[9:5];
		opc = w[30:29];
		sf = w[31];
		hw = w[22:21];
		wmask = sf ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
		top = sf ? 63 : 31;
		bad = 1'b0;
		res = '0;

		if (w[25:23] == OPI_ARITH) begin
			a = (rn == ZERO_REG) ? 64'd0 : shadow_x[rn];
			a = a & wmask;
			b = {52'd0, w[21:10]};
			if (w[22])
				b = b << 12;
			res = (opc[1] ? a - b : a + b) & wmask;
			// flag-setting forms
			if (opc[0]) begin
				if (opc[1]) begin
					c = (a >= b);
					v = (a[top] ^ b[top]) & (a[top] ^ res[top]);
				end else begin
					c = sf ? (res < a) : (((a + b) >> 32) & 64'd1) != 0;
					v = ~(a[top] ^ b[top]) & (a[top] ^ res[top]);
				end
				shadow_nzcv = {res[top], res == 64'd0, c, v};
				flag_updates++;
			end
		end else if (w[25:23] == OPI_WIDE) begin
			op = {48'd0, w[20:5]} << (hw * 16);
			if (opc == OPC_UNDEF || (!sf && hw[1])) begin
				bad = 1'b1;
			end else if (opc == OPC_MOVN) begin
				res = ~op & wmask;
			end else if (opc == OPC_MOVZ) begin
				res = op & wmask;
			end else begin
				old = (rd == ZERO_REG) ? 64'd0 : shadow_x[rd];
				hole = 64'hFFFF << (hw * 16);
				res = ((old & ~hole) | op) & wmask;
			end
		end else begin
			bad = 1'b1;
		end

		// write back, dropped for the zero register and undefined words
		if (bad || rd == ZERO_REG) begin
			res = '0;
			r.written = 1'b0;
		end else begin
			shadow_x[rd] = res;
			r.written = 1'b1;
		end
		if (bad)
			undefined_count++;
		r.dest = rd;
		r.value = res;
		r.nzcv = shadow_nzcv;
		r.invalid = bad;
		return r;
	endfunction

	// sends one instruction word, with random idle cycles ahead of it
	task automatic send_word(input logic [31:0] w);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(execute_word(w));
		words_sent++;
	endtask

	// stops sending and waits for every pending result
	task automatic drain_results();
		int unsigned waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	// compares one result word with the oldest pending one
	task automatic check_result(input dp_result_t got);
		dp_result_t want;
		if (pending_results.size() == 0) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("tb: unexpected result: dest %0d written %b value %h nzcv %b invalid %b",
					got.dest, got.written, got.value, got.nzcv, got.invalid);
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (got.dest !== want.dest || got.written !== want.written ||
				got.value !== want.value || got.nzcv !== want.nzcv ||
				got.invalid !== want.invalid) begin
			error_count++;
			if (error_count <= MAX_REPORTS) begin
				$display("tb: mismatch at result %0d", results_checked);
				$display("  expected dest %0d written %b value %h nzcv %b invalid %b",
					want.dest, want.written, want.value, want.nzcv, want.invalid);
				$display("  actual   dest %0d written %b value %h nzcv %b invalid %b",
					got.dest, got.written, got.value, got.nzcv, got.invalid);
			end
		end
	endtask

	// result side: check accepted words and stall at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result(dp_result_t'(m_axis_tdata[74:0]));
		m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
	end

	// random picks biased toward the extremes and a few hot registers
	function automatic logic [4:0] pick_reg();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 75)
			return 5'($urandom_range(7));
		else if (p < 90)
			return 5'($urandom_range(30));
		return ZERO_REG;
	endfunction

	function automatic logic [11:0] pick_imm12();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 20)
			return 12'h000;
		else if (p < 35)
			return 12'hFFF;
		return 12'($urandom);
	endfunction

	function automatic logic [15:0] pick_imm16();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 15)
			return 16'h0000;
		else if (p < 30)
			return 16'hFFFF;
		else if (p < 40)
			return 16'h8000;
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] random_word();
		int unsigned p;
		logic [31:0] w;
		logic        sf;
		logic [1:0]  opc;
		logic [1:0]  hw;
		p = $urandom_range(99);
		sf = 1'($urandom_range(1));
		if (p < 45) begin
			w = enc_arith(sf, 2'($urandom_range(3)), 1'($urandom_range(1)), pick_imm12(),
				pick_reg(), pick_reg());
		end else if (p < 85) begin
			opc = ($urandom_range(9) == 0) ? OPC_UNDEF : 2'($urandom_range(3));
			if (opc == OPC_UNDEF)
				opc = ($urandom_range(9) == 0) ? OPC_UNDEF : OPC_MOVK;
			hw = 2'($urandom_range(3));
			if (!sf && $urandom_range(9) != 0)
				hw[1] = 1'b0;
			w = enc_wide(sf, opc, hw, pick_imm16(), pick_reg());
		end else begin
			// noise: any word at all
			w = $urandom;
		end
		// bits 28..26 are ignored by the unit
		if (p < 85 && $urandom_range(3) == 0)
			w[28:26] = 3'($urandom_range(7));
		return w;
	endfunction

	// wide moves in both widths, at halfwords 0 and 3 for 64-bit and 0 and 1 for 32-bit
	task automatic test_wide_moves();
		send_word(enc_wide(1'b1, OPC_MOVZ, 2'd3, 16'hFFFF, 5'd0));
		send_word(enc_wide(1'b1, OPC_MOVK, 2'd0, 16'h1234, 5'd0));
		send_word(enc_wide(1'b1, OPC_MOVN, 2'd0, 16'h0000, 5'd1));
		send_word(enc_wide(1'b0, OPC_MOVZ, 2'd1, 16'hFFFF, 5'd7));
		send_word(enc_wide(1'b0, OPC_MOVN, 2'd0, 16'h0000, 5'd8));
		// 32-bit movk clears the upper half of the register
		send_word(enc_wide(1'b0, OPC_MOVK, 2'd1, 16'h0005, 5'd0));
		drain_results();
	endtask

	// add/sub with carry and signed overflow at both widths, and borrow at 64 bits
	task automatic test_arith_flags();
		send_word(enc_arith(1'b1, ARITH_ADDS, 1'b0, 12'd1, 5'd1, 5'd2));
		send_word(enc_arith(1'b0, ARITH_ADDS, 1'b0, 12'd1, 5'd1, 5'd3));
		send_word(enc_arith(1'b1, ARITH_SUBS, 1'b0, 12'd1, ZERO_REG, 5'd4));
		send_word(enc_arith(1'b1, ARITH_ADD, 1'b1, 12'hFFF, 5'd0, 5'd5));
		send_word(enc_arith(1'b0, ARITH_SUB, 1'b0, 12'd1, 5'd0, 5'd6));
		send_word(enc_wide(1'b1, OPC_MOVN, 2'd3, 16'h8000, 5'd10));
		send_word(enc_arith(1'b1, ARITH_ADDS, 1'b0, 12'd1, 5'd10, 5'd11));
		send_word(enc_wide(1'b1, OPC_MOVZ, 2'd3, 16'h8000, 5'd13));
		send_word(enc_arith(1'b1, ARITH_SUBS, 1'b0, 12'd1, 5'd13, 5'd12));
		send_word(enc_wide(1'b0, OPC_MOVN, 2'd1, 16'h8000, 5'd15));
		send_word(enc_arith(1'b0, ARITH_ADDS, 1'b0, 12'd1, 5'd15, 5'd16));
		// class bits other than the real ones still execute
		send_word({1'b1, ARITH_ADD, 3'b000, OPI_ARITH, 1'b0, 12'h7FF, 5'd16, 5'd17});
		drain_results();
	endtask

	// zero register as source and destination
	task automatic test_zero_register();
		send_word(enc_arith(1'b1, ARITH_SUBS, 1'b0, 12'd0, 5'd2, ZERO_REG));
		send_word(enc_wide(1'b1, OPC_MOVK, 2'd2, 16'hBEEF, ZERO_REG));
		send_word(enc_arith(1'b1, ARITH_ADD, 1'b0, 12'hABC, ZERO_REG, 5'd14));
		drain_results();
	endtask

	// undefined groups and wide moves that are unallocated
	task automatic test_undefined_encodings();
		send_word(enc_wide(1'b0, OPC_MOVZ, 2'd2, 16'h1111, 5'd9));
		send_word(enc_wide(1'b0, OPC_MOVN, 2'd3, 16'h2222, 5'd9));
		send_word(enc_wide(1'b1, OPC_UNDEF, 2'd0, 16'h3333, 5'd9));
		send_word({1'b1, ARITH_ADDS, CLASS_DPI, 3'b000, 23'h12345});
		send_word(32'hFFFF_FFFF);
		drain_results();
	endtask

	// random words under one mix of sender idling and receiver stalls
	task automatic test_random_stream(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		repeat (count)
			send_word(random_word());
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < 31; i++)
			shadow_x[i] = '0;
		shadow_nzcv = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wide_moves();
		test_arith_flags();
		test_zero_register();
		test_undefined_encodings();
		test_random_stream(150, 0, 0);
		test_random_stream(150, 49, 0);
		test_random_stream(150, 0, 49);
		test_random_stream(150, 28, 28);

		// anything still pending never arrived
		error_count += pending_results.size();
		$display("tb: %0d instruction words sent, %0d results checked, four idling mixes",
			words_sent, results_checked);
		$display("tb: %0d undefined encodings, %0d flag-setting operations",
			undefined_count, flag_updates);
		if (error_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: %0d errors", error_count);
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/a64dp_pkg.sv
rtl/a64dp_ram.sv
rtl/a64dp_alu.sv
rtl/a64_immediate_data_processing.sv
verif/tb.sv
